// ----- design/lzwd_pkg.sv -----
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared constants and controller/datapath interface types for the LZSS
// window decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lzwd_pkg;

   // Window size is 2**LZWD_WINDOW_BITS (8..16 bits, 256..65536 entries)
   localparam int LZWD_WINDOW_BITS     = 12;
   localparam int LZWD_MAX_MATCH       = 60;
   localparam int LZWD_MATCH_THRESHOLD = 2;

   localparam int CODE_W = 9;
   localparam int POS_W  = 12;
   localparam int BYTE_W = 8;

   localparam logic [CODE_W-1:0] LITERAL_LIMIT = 9'd256;
   localparam logic [CODE_W:0]   MATCH_BASE    = 10'd255;
   localparam logic [BYTE_W-1:0] FILL_BYTE     = 8'h20;

   // controller -> datapath
   typedef struct packed {
      logic lit_write;   // store literal, load result register
      logic load_match;  // capture source index and length
      logic issue_read;  // read window at source index
      logic emit_copy;   // write back copied byte, load result register
   } lzwd_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;    // result register empty or being drained this cycle
      logic last_byte;   // current copy byte is the final one
   } lzwd_status_type;

endpackage

// ----- design/lzwd_ctrl.sv -----
// ----------------------------------------------------------------------------
// lzwd_ctrl
// Sequencer: accepts symbols and steps match copies through read and
// write-back phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzwd_ctrl
   import lzwd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CODE_W-1:0]   req_symbol_code,
   input  lzwd_status_type     status,
   output lzwd_cmd_type        cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;
   logic       is_literal;

   assign req_ready  = (state_ff == ST_IDLE) && status.out_free;
   assign accept     = req_valid && req_ready;
   assign is_literal = req_symbol_code < LITERAL_LIMIT;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_literal) begin
                  cmd.lit_write = 1'b1;
               end else begin
                  cmd.load_match = 1'b1;
                  state_in       = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.issue_read = 1'b1;
            state_in       = ST_WRITE;
         end
         ST_WRITE: begin
            if (status.out_free) begin
               cmd.emit_copy = 1'b1;
               state_in      = status.last_byte ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/lzwd_datapath.sv -----
// ----------------------------------------------------------------------------
// lzwd_datapath
// Ring window memory, write pointer, fill count, copy source/length and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzwd_datapath
   import lzwd_pkg::*;
#(
   parameter int WINDOW_BITS     = LZWD_WINDOW_BITS,
   parameter int MAX_MATCH       = LZWD_MAX_MATCH,
   parameter int MATCH_THRESHOLD = LZWD_MATCH_THRESHOLD
)(
   input  logic                clock,
   input  logic                reset,
   input  lzwd_cmd_type        cmd,
   output lzwd_status_type     status,
   input  logic [CODE_W-1:0]   req_symbol_code,
   input  logic [POS_W-1:0]    req_match_position,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_last_of_run
);

   localparam int WS    = 1 << WINDOW_BITS;
   localparam int LEN_W = $clog2(MAX_MATCH + 1);
   localparam int EXT_W = (POS_W > WINDOW_BITS) ? POS_W : WINDOW_BITS;
   localparam logic [WINDOW_BITS-1:0] BASE     = WINDOW_BITS'(WS - MAX_MATCH);
   localparam logic [WINDOW_BITS:0]   FILL_MAX = (WINDOW_BITS+1)'(WS);

   logic [BYTE_W-1:0] window_mem [WS];

   logic [WINDOW_BITS-1:0] wp_ff, wp_in;
   logic [WINDOW_BITS:0]   fill_ff, fill_in;
   logic [WINDOW_BITS-1:0] src_ff, src_in;
   logic [LEN_W-1:0]       remain_ff, remain_in;
   logic [BYTE_W-1:0]      rd_data_ff;
   logic                   rd_written_ff, rd_written_in;
   logic                   rd_spaces_ff, rd_spaces_in;
   logic                   valid_ff, valid_in;
   logic [BYTE_W-1:0]      byte_ff, byte_in;
   logic                   last_ff, last_in;

   logic                   do_write;
   logic [BYTE_W-1:0]      wr_byte;
   logic [BYTE_W-1:0]      copy_byte;
   logic [CODE_W:0]        len_full;
   logic [EXT_W-1:0]       pos_ext;
   logic [WINDOW_BITS-1:0] pos_mod;
   logic [WINDOW_BITS-1:0] src_offset;

   assign status.out_free  = !valid_ff || rsp_ready;
   assign status.last_byte = remain_ff == LEN_W'(1);

   assign pos_ext = EXT_W'(req_match_position);
   assign pos_mod = pos_ext[WINDOW_BITS-1:0];
   assign len_full = {1'b0, req_symbol_code} - MATCH_BASE
                     + (CODE_W+1)'(MATCH_THRESHOLD);

   // never-written entries read as spaces below BASE, zero above
   assign copy_byte = rd_written_ff ? rd_data_ff : (rd_spaces_ff ? FILL_BYTE : '0);
   assign do_write  = cmd.lit_write || cmd.emit_copy;
   assign wr_byte   = cmd.lit_write ? req_symbol_code[BYTE_W-1:0] : copy_byte;

   // entries written so far run from BASE forward, fill_ff of them
   assign src_offset    = src_ff - BASE;
   assign rd_written_in = {1'b0, src_offset} < fill_ff;
   assign rd_spaces_in  = src_ff < BASE;

   always_comb begin
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      src_in    = src_ff;
      remain_in = remain_ff;
      valid_in  = valid_ff && !rsp_ready;
      byte_in   = byte_ff;
      last_in   = last_ff;
      if (do_write) begin
         wp_in    = wp_ff + WINDOW_BITS'(1);
         valid_in = 1'b1;
         if (fill_ff != FILL_MAX) begin
            fill_in = fill_ff + (WINDOW_BITS+1)'(1);
         end
      end
      if (cmd.lit_write) begin
         byte_in = req_symbol_code[BYTE_W-1:0];
         last_in = 1'b1;
      end
      if (cmd.emit_copy) begin
         byte_in   = copy_byte;
         last_in   = status.last_byte;
         remain_in = remain_ff - LEN_W'(1);
      end
      if (cmd.load_match) begin
         src_in = wp_ff - pos_mod - WINDOW_BITS'(1);
         if (len_full > (CODE_W+1)'(MAX_MATCH)) begin
            remain_in = LEN_W'(MAX_MATCH);
         end else begin
            remain_in = len_full[LEN_W-1:0];
         end
      end
      if (cmd.issue_read) begin
         src_in = src_ff + WINDOW_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         window_mem[wp_ff] <= wr_byte;
      end
      if (cmd.issue_read) begin
         rd_data_ff <= window_mem[src_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue_read) begin
         rd_written_ff <= rd_written_in;
         rd_spaces_ff  <= rd_spaces_in;
      end
      src_ff    <= src_in;
      remain_ff <= remain_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= BASE;
         fill_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         wp_ff    <= wp_in;
         fill_ff  <= fill_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("fill count beyond window size");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.lit_write && cmd.emit_copy))
      else $error("literal and copy write in the same cycle");

   a_lit_result: assert property (@(posedge clock) disable iff (reset)
      cmd.lit_write |=> rsp_valid && rsp_last_of_run)
      else $error("literal did not produce a final result item");

   a_wp_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      do_write |=> wp_ff == $past(wp_ff) + WINDOW_BITS'(1))
      else $error("write pointer did not advance on write");

endmodule

// ----- design/lzss_window_decoder.sv -----
// ----------------------------------------------------------------------------
// lzss_window_decoder
// LZSS ring-window decoder: literals and back-references to output bytes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_ready  | symbol_code[8:0], match_position[11:0]
//  rsp_    | out       | rsp_valid/rsp_ready  | out_byte[7:0], last_of_run
//
//  Literal: one item per cycle while rsp_ can drain. Match: an accept step, then
//  a read phase and a write-back phase per copied byte (window read port is
//  registered, write-back follows); the next symbol waits until the copy ends.
//  Reset takes effect at once; no clearing pass: a fill count marks which
//  window entries were written, others read as spaces or zero.
//  A stalled rsp_ holds the copy in its write-back phase; req_ready drops
//  whenever a match is in progress or the result register cannot drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzss_window_decoder
   import lzwd_pkg::*;
#(
   parameter int WINDOW_BITS     = LZWD_WINDOW_BITS,
   parameter int MAX_MATCH       = LZWD_MAX_MATCH,
   parameter int MATCH_THRESHOLD = LZWD_MATCH_THRESHOLD
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CODE_W-1:0]   req_symbol_code,
   input  logic [POS_W-1:0]    req_match_position,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_last_of_run
);

   lzwd_cmd_type    cmd;
   lzwd_status_type status;

   lzwd_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_symbol_code (req_symbol_code),
      .status          (status),
      .cmd             (cmd)
   );

   lzwd_datapath #(
      .WINDOW_BITS     (WINDOW_BITS),
      .MAX_MATCH       (MAX_MATCH),
      .MATCH_THRESHOLD (MATCH_THRESHOLD)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_symbol_code    (req_symbol_code),
      .req_match_position (req_match_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule
